### src/smallest_free_id_allocator_defines.svh
// Assertion macros for the smallest-free-ID allocator.
// No dependencies; the files that assert include this header.
`ifndef SMALLEST_FREE_ID_ALLOCATOR_DEFINES_SVH
`define SMALLEST_FREE_ID_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SFIA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SFIA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFIA_ASSERT_NOW(lbl, ante, cons, msg)
`define SFIA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/sfia_pkg.sv
// Shared constants, state encoding and bit-search function of the allocator.
// No dependencies; used by every module of the block.
`default_nettype none
package sfia_pkg;

	localparam int NUM_IDS_DEF = 1024;
	localparam int WORD_W      = 32;
	localparam int BIT_W       = 5;
	localparam int ID_W        = 10;
	localparam int TDATA_W     = 16;

	typedef enum logic [4:0] {
		ST_INIT    = 5'b00001,
		ST_IDLE    = 5'b00010,
		ST_ADD_WR  = 5'b00100,
		ST_POP_CHK = 5'b01000,
		ST_SCAN    = 5'b10000
	} state_t;

	// Index of the lowest set bit; zero when the word is empty.
	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### src/sfia_map_mem.sv
// Free bitmap storage: one write port, one read port, registered read data.
// Depends on sfia_pkg for the word width.
`default_nettype none
module sfia_map_mem #(
	parameter int WW = 5
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [WW-1:0]                waddr,
	input  wire logic [sfia_pkg::WORD_W-1:0]  wdata,
	input  wire logic [WW-1:0]                raddr,
	output logic      [sfia_pkg::WORD_W-1:0]  rdata
);

	logic [sfia_pkg::WORD_W-1:0] mem [2**WW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/sfia_word_find.sv
// Finds the lowest free ID in one bitmap word, above an optional floor bit
// and below NUM_IDS. Depends on sfia_pkg for widths and the bit search.
`default_nettype none
module sfia_word_find #(
	parameter int NUM_IDS = sfia_pkg::NUM_IDS_DEF,
	parameter int WW      = 5
) (
	input  wire logic [sfia_pkg::WORD_W-1:0] word,
	input  wire logic [WW-1:0]               widx,
	input  wire logic                        floor_en,
	input  wire logic [sfia_pkg::BIT_W-1:0]  floor_bit,
	output logic                             hit,
	output logic [sfia_pkg::BIT_W-1:0]       bit_idx
);

	localparam int LAST_W   = (NUM_IDS - 1) / sfia_pkg::WORD_W;
	localparam int LAST_CNT = NUM_IDS - LAST_W * sfia_pkg::WORD_W;
	localparam logic [sfia_pkg::WORD_W-1:0] LAST_MASK =
		sfia_pkg::WORD_W'((64'd1 << LAST_CNT) - 64'd1);

	logic [sfia_pkg::WORD_W-1:0] range_mask;
	logic [sfia_pkg::WORD_W-1:0] above_mask;
	logic [sfia_pkg::WORD_W-1:0] cand;

	always_comb begin
		range_mask = (widx == WW'(LAST_W)) ? LAST_MASK : '1;
		// Shifting two left by the floor bit leaves only bits strictly above it.
		above_mask = floor_en ? ~((32'd2 << floor_bit) - 32'd1) : '1;
		cand       = word & range_mask & above_mask;
		hit        = |cand;
		bit_idx    = sfia_pkg::first_set(cand);
	end

endmodule
`default_nettype wire

### src/smallest_free_id_allocator.sv
// Smallest-free-ID allocator: a pop clears its bit in the pointer's word and searches
// above it; if none is free there, it scans the next bitmap words, one word per cycle.
// An add-back reads the word, then writes the word back with the ID's bit set.
// After reset the bitmap is filled with ones, one 32-bit word per cycle,
// (NUM_IDS+31)/32 words (32 for 1024 IDs), before the first item is accepted.
`default_nettype none
`include "smallest_free_id_allocator_defines.svh"
module smallest_free_id_allocator #(
	parameter int NUM_IDS = sfia_pkg::NUM_IDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Request side.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [sfia_pkg::TDATA_W-1:0]  s_tdata,  // [9:0] id_value, rest zero
	input  wire logic                          s_tuser,  // [0] req_type (1 = add back)
	// Result side.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [sfia_pkg::TDATA_W-1:0]       m_tdata,  // [9:0] popped_id, rest zero
	output logic                               m_tuser   // [0] exhausted
);

	// The ID width never drops below one word index bit plus the bit offset.
	localparam int IW     = ($clog2(NUM_IDS) < 6) ? 6 : $clog2(NUM_IDS);
	localparam int WW     = IW - sfia_pkg::BIT_W;
	localparam int LAST_W = (NUM_IDS - 1) / sfia_pkg::WORD_W;
	localparam int BW     = sfia_pkg::BIT_W;

	sfia_pkg::state_t state_q;

	logic [IW-1:0] lp_q;        // low-water pointer: smallest free ID
	logic          none_q;      // no free ID left
	logic [WW-1:0] clr_w_q;     // word being filled during the clearing pass
	logic          chk_v_q;     // read data in the scan belongs to chk_w_q
	logic [WW-1:0] scan_w_q;    // word address issued this cycle during a scan
	logic [WW-1:0] chk_w_q;     // word whose data arrives this cycle
	logic [WW-1:0] add_w_q;     // word of the ID being added back
	logic [BW-1:0] add_b_q;     // bit of the ID being added back

	logic                          out_v_q;
	logic [sfia_pkg::ID_W-1:0]     out_id_q;
	logic                          out_ex_q;

	logic                          mem_we;
	logic [WW-1:0]                 mem_waddr;
	logic [sfia_pkg::WORD_W-1:0]   mem_wdata;
	logic [WW-1:0]                 mem_raddr;
	logic [sfia_pkg::WORD_W-1:0]   mem_rdata;

	logic [sfia_pkg::WORD_W-1:0]   pop_cleared;
	logic [sfia_pkg::WORD_W-1:0]   find_word;
	logic [WW-1:0]                 find_widx;
	logic                          find_floor;
	logic                          find_hit;
	logic [BW-1:0]                 find_idx;

	logic                          s_fire;
	logic                          pop_fire;
	logic                          add_fire;
	logic                          id_ok;
	logic [IW-1:0]                 id_int;
	logic [WW-1:0]                 lp_word;

	// Handshake. A request is taken only in the idle state and only when the
	// result register is free or being emptied, so a pop can load its result
	// at once: the ID it returns is already known from the pointer.
	assign s_tready = (state_q == sfia_pkg::ST_IDLE) && (!out_v_q || m_tready);
	assign s_fire   = s_tvalid && s_tready;
	assign pop_fire = s_fire && !s_tuser;
	assign add_fire = s_fire && s_tuser;

	// IDs of zero or of NUM_IDS and above are ignored on add-back.
	assign id_ok   = (s_tdata[sfia_pkg::ID_W-1:0] != '0) &&
		(32'(s_tdata[sfia_pkg::ID_W-1:0]) < NUM_IDS);
	assign id_int  = IW'(s_tdata[sfia_pkg::ID_W-1:0]);
	assign lp_word = lp_q[IW-1:BW];

	assign m_tvalid = out_v_q;
	assign m_tdata  = sfia_pkg::TDATA_W'(out_id_q);
	assign m_tuser  = out_ex_q;

	// The popped ID's bit is cleared in the word read for it.
	assign pop_cleared = mem_rdata & ~(32'd1 << lp_q[BW-1:0]);

	// Read address: the scan walks words; otherwise the address follows the
	// request at the port so the data is ready in the next state.
	always_comb begin
		case (state_q)
			sfia_pkg::ST_SCAN: begin
				mem_raddr = scan_w_q;
			end
			default: begin
				mem_raddr = s_tuser ? id_int[IW-1:BW] : lp_word;
			end
		endcase
	end

	// Write port: clearing pass, add-back write-back, pop write-back.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lp_word;
		mem_wdata = pop_cleared;
		case (state_q)
			sfia_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_w_q;
				mem_wdata = '1;
			end
			sfia_pkg::ST_ADD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = add_w_q;
				mem_wdata = mem_rdata | (32'd1 << add_b_q);
			end
			sfia_pkg::ST_POP_CHK: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// The search unit looks above the popped bit in the first word and at
	// whole words during the scan.
	always_comb begin
		if (state_q == sfia_pkg::ST_POP_CHK) begin
			find_word  = pop_cleared;
			find_widx  = lp_word;
			find_floor = 1'b1;
		end else begin
			find_word  = mem_rdata;
			find_widx  = chk_w_q;
			find_floor = 1'b0;
		end
	end

	sfia_map_mem #(
		.WW(WW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sfia_word_find #(
		.NUM_IDS(NUM_IDS),
		.WW     (WW)
	) u_find (
		.word     (find_word),
		.widx     (find_widx),
		.floor_en (find_floor),
		.floor_bit(lp_q[BW-1:0]),
		.hit      (find_hit),
		.bit_idx  (find_idx)
	);

	// Control state: sequencer, pointer, exhausted flag, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfia_pkg::ST_INIT;
			lp_q    <= IW'(1);
			none_q  <= 1'b0;
			clr_w_q <= '0;
			chk_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (pop_fire) begin
				out_v_q <= 1'b1;
			end
			case (state_q)
				sfia_pkg::ST_INIT: begin
					clr_w_q <= clr_w_q + WW'(1);
					if (clr_w_q == WW'(LAST_W)) begin
						state_q <= sfia_pkg::ST_IDLE;
					end
				end
				sfia_pkg::ST_IDLE: begin
					if (pop_fire && !none_q) begin
						state_q <= sfia_pkg::ST_POP_CHK;
					end
					if (add_fire && id_ok) begin
						state_q <= sfia_pkg::ST_ADD_WR;
						// An add-back while exhausted always takes the pointer.
						if (none_q || (id_int < lp_q)) begin
							lp_q <= id_int;
						end
						none_q <= 1'b0;
					end
				end
				sfia_pkg::ST_ADD_WR: begin
					state_q <= sfia_pkg::ST_IDLE;
				end
				sfia_pkg::ST_POP_CHK: begin
					chk_v_q <= 1'b0;
					if (find_hit) begin
						lp_q    <= {lp_word, find_idx};
						state_q <= sfia_pkg::ST_IDLE;
					end else if (lp_word == WW'(LAST_W)) begin
						none_q  <= 1'b1;
						state_q <= sfia_pkg::ST_IDLE;
					end else begin
						state_q <= sfia_pkg::ST_SCAN;
					end
				end
				sfia_pkg::ST_SCAN: begin
					chk_v_q <= 1'b1;
					if (chk_v_q) begin
						if (find_hit) begin
							lp_q    <= {chk_w_q, find_idx};
							state_q <= sfia_pkg::ST_IDLE;
						end else if (chk_w_q == WW'(LAST_W)) begin
							// The pointer keeps the last popped ID.
							none_q  <= 1'b1;
							state_q <= sfia_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= sfia_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: scan addresses, add-back position, result fields.
	always_ff @(posedge clk) begin
		if (state_q == sfia_pkg::ST_POP_CHK) begin
			scan_w_q <= lp_word + WW'(1);
		end else if (state_q == sfia_pkg::ST_SCAN) begin
			scan_w_q <= scan_w_q + WW'(1);
			chk_w_q  <= scan_w_q;
		end
		if (add_fire) begin
			add_w_q <= id_int[IW-1:BW];
			add_b_q <= id_int[BW-1:0];
		end
		if (pop_fire) begin
			out_id_q <= none_q ? '0 : sfia_pkg::ID_W'(lp_q);
			out_ex_q <= none_q;
		end
	end

	`SFIA_ASSERT_NEXT(a_pop_exhausted, pop_fire && none_q, m_tvalid && m_tuser, "exhausted pop did not flag its result")
	`SFIA_ASSERT_NEXT(a_pop_id, pop_fire && !none_q, m_tvalid && !m_tuser && (m_tdata[sfia_pkg::ID_W-1:0] == $past(sfia_pkg::ID_W'(lp_q))), "pop result is not the pointer")
	`SFIA_ASSERT_NOW(a_ptr_nonzero, state_q != sfia_pkg::ST_INIT, lp_q != '0, "pointer reached ID zero")
	`SFIA_ASSERT_NOW(a_scan_no_write, state_q == sfia_pkg::ST_SCAN, !mem_we, "bitmap written during a scan")

endmodule
`default_nettype wire

### tb/sv/sfia_tb_pkg.sv
// Request codes and the scoreboard class of the allocator testbench.
// Depends on sfia_pkg for the ID width and the size of the ID space.
package sfia_tb_pkg;

	import sfia_pkg::*;

	localparam bit REQ_POP = 1'b0;
	localparam bit REQ_ADD = 1'b1;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [ID_W-1:0] popped_id;
		logic            exhausted;
	} grant_t;

	// Tracks the free set as the block should see it and holds the grants
	// still owed, oldest first.
	class id_alloc_scoreboard;

		bit [NUM_IDS_DEF-1:0] free_map;
		logic [ID_W-1:0]      low_ptr;
		bit                   none_left;
		grant_t               owed_grants[$];

		int requests;
		int pops;
		int add_backs;
		int ignored_adds;
		int exhausted_grants;
		int mismatches;
		int strays;

		function new();
			free_map = '1;
			low_ptr = ID_W'(1);
			none_left = 1'b0;
		endfunction

		// Applies one accepted request to the free set and queues the grant
		// that a pop owes.
		function void note_request(bit req, logic [ID_W-1:0] id);
			grant_t g;
			int k;
			bit found;
			requests++;
			if (req == REQ_POP) begin
				pops++;
				if (none_left) begin
					g.popped_id = '0;
					g.exhausted = 1'b1;
					exhausted_grants++;
				end else begin
					g.popped_id = low_ptr;
					g.exhausted = 1'b0;
					free_map[low_ptr] = 1'b0;
					found = 1'b0;
					for (k = int'(low_ptr) + 1; k < NUM_IDS_DEF && !found; k++) begin
						if (free_map[k]) begin
							low_ptr = ID_W'(k);
							found = 1'b1;
						end
					end
					// The last free ID is gone: the pointer stays where it was.
					if (!found)
						none_left = 1'b1;
				end
				owed_grants.push_back(g);
			end else begin
				add_backs++;
				if (id == '0 || int'(id) >= NUM_IDS_DEF) begin
					ignored_adds++;
				end else begin
					free_map[id] = 1'b1;
					if (none_left) begin
						low_ptr = id;
						none_left = 1'b0;
					end else if (id < low_ptr) begin
						low_ptr = id;
					end
				end
			end
		endfunction

		// Compares one grant taken from the block with the oldest one owed.
		function void check_grant(logic [ID_W-1:0] popped_id, logic exhausted);
			grant_t want;
			if (owed_grants.size() == 0) begin
				strays++;
				if (mismatches + strays <= MAX_REPORTS)
					$display("stray grant: id=%0d exhausted=%0b", popped_id, exhausted);
				return;
			end
			want = owed_grants.pop_front();
			if (popped_id !== want.popped_id || exhausted !== want.exhausted) begin
				mismatches++;
				if (mismatches + strays <= MAX_REPORTS)
					$display("grant mismatch: want id=%0d exhausted=%0b, got id=%0d exhausted=%0b",
						want.popped_id, want.exhausted, popped_id, exhausted);
			end
		endfunction

		function int pending();
			return owed_grants.size();
		endfunction

		// A used ID near a random spot, so that add-backs really free something.
		function logic [ID_W-1:0] pick_used_id();
			int start;
			int k;
			int idx;
			start = $urandom_range(1, NUM_IDS_DEF - 1);
			for (k = 0; k < NUM_IDS_DEF - 1; k++) begin
				idx = 1 + (start - 1 + k) % (NUM_IDS_DEF - 1);
				if (!free_map[idx])
					return ID_W'(idx);
			end
			return ID_W'(start);
		endfunction

		function int failures();
			return mismatches + strays + owed_grants.size();
		endfunction

	endclass

endpackage

### tb/sv/tb.sv
// Testbench top of the smallest-free-ID allocator: drives requests in bursts,
// stalls the grant side, and checks every grant against the scoreboard.
// Depends on sfia_pkg, sfia_tb_pkg and the allocator RTL.
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sfia_pkg::*;
	import sfia_tb_pkg::*;

	// Generous bound on the length of the slowest correct run.
	localparam int CYCLE_LIMIT   = 600000;
	localparam int ITEM_TARGET   = 1450;
	localparam int LONG_HOLD     = 400;
	// Extra wait at the end, longer than the longest pop.
	localparam int TAIL_CYCLES   = 60;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	id_alloc_scoreboard sb;

	// Handshake between the stimulus and the grant-side process: a request
	// for one long hold-off of the grant side.
	bit hold_off_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int rx_mode = 0;
	int rx_window = 0;
	int long_holds = 0;
	int cycles = 0;

	// Burst state of the request side.
	int burst_left = 0;

	smallest_free_id_allocator #(
		.NUM_IDS(NUM_IDS_DEF)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The cycle counter is the only timeout of the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d grants still owed", cycles, sb.pending());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Monitor: values are read in the active region of the edge, before any
	// nonblocking update, so they are the values that the block saw. The grant
	// is checked before the request is noted, though a grant can never belong
	// to a request accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_grant(m_tdata[ID_W-1:0], m_tuser);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[ID_W-1:0]);
		end
	end

	// Grant side. At the start of each window it picks a new stall pattern: always ready,
	// short stalls, coin-flip readiness or rare long stalls. A requested
	// hold-off overrides all of them and is counted here.
	always @(posedge clk) begin
		if (rx_window == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_window = 128;
		end
		rx_window--;
		if (hold_off_req) begin
			hold_left = LONG_HOLD;
			hold_off_req <= 1'b0;
			long_holds++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					if ($urandom_range(0, 5) == 0) begin
						stall_left = $urandom_range(0, 3);
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
				2: begin
					m_tready <= ($urandom_range(0, 1) != 0);
				end
				default: begin
					if ($urandom_range(0, 19) == 0) begin
						stall_left = $urandom_range(10, 40);
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Offers one request and returns right after the edge that accepted it.
	// A new burst may start with a gap; valid is only lowered when that gap is
	// not zero, so it never drops and rises within one step.
	task automatic send_request(bit req, logic [ID_W-1:0] id);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= TDATA_W'(id);
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Stops offering and waits until every owed grant has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int r;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Pops carry junk in the ID field, which must be ignored.
		send_request(REQ_POP, ID_W'(0));
		send_request(REQ_POP, '1);
		send_request(REQ_POP, ID_W'(10'h2AA));
		// ID zero is out of range and changes nothing.
		send_request(REQ_ADD, ID_W'(0));
		// The top ID is already free and above the pointer.
		send_request(REQ_ADD, '1);
		// Returning a used ID below the pointer lowers the pointer to it.
		send_request(REQ_ADD, ID_W'(2));
		send_request(REQ_POP, ID_W'(10'h155));
		send_request(REQ_POP, ID_W'(0));
		send_request(REQ_ADD, ID_W'(1));
		// ID 3 is above the new pointer: freed, but the pointer stays at 1.
		send_request(REQ_ADD, ID_W'(3));
		send_request(REQ_POP, '1);
		send_request(REQ_POP, ID_W'(0));
		send_request(REQ_POP, ID_W'(0));
		send_request(REQ_ADD, ID_W'(10'h155));
		send_request(REQ_ADD, ID_W'(10'h2AA));
		send_request(REQ_POP, ID_W'(10'h155));
		wait_drained();

		// Drain the whole set with a few add-backs sprinkled in, so that the
		// last free ID is popped and the scan runs off the top of the map.
		while (!sb.none_left) begin
			if ($urandom_range(0, 15) == 0)
				send_request(REQ_ADD, ID_W'($urandom_range(0, NUM_IDS_DEF - 1)));
			else
				send_request(REQ_POP, ID_W'($urandom));
		end

		// Exhausted: pops get the exhausted flag, and an add-back revives the
		// set with the pointer jumping straight to the returned ID.
		repeat (3) send_request(REQ_POP, ID_W'($urandom));
		send_request(REQ_ADD, ID_W'(0));
		send_request(REQ_POP, ID_W'(0));
		repeat (12) begin
			send_request(REQ_ADD, sb.pick_used_id());
			send_request(REQ_POP, ID_W'($urandom));
			send_request(REQ_POP, ID_W'($urandom));
		end
		wait_drained();

		// Hold the grant side off for a long stretch while back-to-back pops
		// keep coming, so the block fills up and stalls its request side.
		hold_off_req <= 1'b1;
		burst_left = 64;
		repeat (40) send_request(REQ_POP, ID_W'($urandom));
		repeat (40) send_request(REQ_ADD, sb.pick_used_id());

		// Mixed traffic: mostly pops and add-backs of used IDs, with a few
		// add-backs of arbitrary IDs that may be free already or out of range.
		while (sb.requests < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_request(REQ_POP, ID_W'($urandom));
			else if (r < 90)
				send_request(REQ_ADD, sb.pick_used_id());
			else
				send_request(REQ_ADD, ID_W'($urandom_range(0, NUM_IDS_DEF - 1)));
			if (sb.requests == ITEM_TARGET - 200)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d pops, %0d add-backs (%0d ignored)",
			sb.requests, sb.pops, sb.add_backs, sb.ignored_adds);
		$display("%0d exhausted grants, %0d long hold-offs, %0d mismatches, %0d stray grants",
			sb.exhausted_grants, long_holds, sb.mismatches, sb.strays);
		if (sb.failures() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/sfia_pkg.sv
src/sfia_map_mem.sv
src/sfia_word_find.sv
src/smallest_free_id_allocator.sv
tb/sv/sfia_tb_pkg.sv
tb/sv/tb.sv
